[rtl/core/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising clock, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/mau_pkg.sv]
`default_nettype none
package mau_pkg;

  localparam int MAU_WIDTH = 32;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_INV = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOINV   = 2'd1;
  localparam logic [1:0] ST_ZEROMOD = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_DISP,
    S_MUL_DBL,
    S_MUL_ADD,
    S_EU_CHK,
    S_EU_DIV,
    S_EU_ACC,
    S_EU_UPD,
    S_DONE
  } mau_state_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
  } mau_res_t;

endpackage
`default_nettype wire

[rtl/core/modular_arithmetic_unit.sv]
// Modular add, subtract, multiply and inverse on WIDTH-bit unsigned operands, one item at a
// time over a bit-serial datapath. Both operands are first reduced modulo the modulus one bit
// per cycle. Add and subtract then finish in the dispatch state, multiply runs double-and-add
// over the bits of the reduced second operand, and inverse runs extended Euclid where each
// quotient is found bit by bit by long division. A zero modulus goes from idle straight to done.
// Results sit in an output register, so the next word is taken while one waits.
`default_nettype none
module modular_arithmetic_unit #(
  parameter int WIDTH = mau_pkg::MAU_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // operand_a, operand_b, modulus
  input  wire logic [((3*WIDTH+7)/8)*8-1:0]      s_tdata,
  // kind
  input  wire logic [1:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // result
  output logic [((WIDTH+7)/8)*8-1:0]             m_tdata,
  // status
  output logic [1:0]                             m_tuser
);
  import mau_pkg::*;

  localparam int OW = ((WIDTH + 7) / 8) * 8;

  mau_res_t         info;
  logic [WIDTH-1:0] core_res, res_q;
  logic [1:0]       st_q;
  logic             take;

  assign take = !m_tvalid || m_tready;

  mau_core #(.WIDTH(WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .operand_a (s_tdata[WIDTH-1:0]),
    .operand_b (s_tdata[2*WIDTH-1:WIDTH]),
    .modulus   (s_tdata[3*WIDTH-1:2*WIDTH]),
    .res_info  (info),
    .result    (core_res),
    .out_take  (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (info.done && take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (info.done && take) begin
      res_q <= core_res;
      st_q  <= info.status;
    end
  end

  assign m_tdata = OW'(res_q);
  assign m_tuser = st_q;

endmodule
`default_nettype wire

[rtl/core/mau_core.sv]
`default_nettype none
`include "assert_macros.svh"
module mau_core #(
  parameter int WIDTH = mau_pkg::MAU_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       kind,
  input  wire logic [WIDTH-1:0] operand_a,
  input  wire logic [WIDTH-1:0] operand_b,
  input  wire logic [WIDTH-1:0] modulus,
  output mau_pkg::mau_res_t     res_info,
  output logic [WIDTH-1:0]      result,
  input  wire logic             out_take
);
  import mau_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  mau_state_t state, state_next;

  logic [1:0]       kind_q;
  logic [WIDTH-1:0] m, a, b, da, db, acc, res, rp, rc, cp, cc, rem, dv;
  logic [1:0]       st;
  logic [CW-1:0]    cnt;
  logic             qbit;

  // shared modular adder
  logic [WIDTH-1:0] am_x, am_y, am_s;
  logic [WIDTH:0]   am_sum;
  always_comb begin
    am_x = acc;
    am_y = acc;
    case (state)
      S_DISP:    begin am_x = a; am_y = b; end
      S_MUL_ADD: am_y = a;
      S_EU_ACC:  am_y = cc;
      default:   am_y = acc;
    endcase
    am_sum = {1'b0, am_x} + {1'b0, am_y};
    am_s = (am_sum >= {1'b0, m}) ? WIDTH'(am_sum - {1'b0, m}) : am_sum[WIDTH-1:0];
  end

  // shared modular subtractor
  logic [WIDTH-1:0] sm_x, sm_y, sm_d, sm_s;
  always_comb begin
    if (state == S_DISP) begin
      sm_x = a;
      sm_y = b;
    end else begin
      sm_x = cp;
      sm_y = acc;
    end
    sm_d = sm_x - sm_y;
    sm_s = (sm_x >= sm_y) ? sm_d : sm_d + m;
  end

  // restoring reduction steps for both operands and the Euclid division step
  logic [WIDTH:0]   sh_a, sh_b, sh_r;
  logic [WIDTH-1:0] a_step, b_step, r_step;
  logic             r_ge;
  always_comb begin
    sh_a = {a, da[WIDTH-1]};
    sh_b = {b, db[WIDTH-1]};
    sh_r = {rem, dv[WIDTH-1]};
    a_step = (sh_a >= {1'b0, m}) ? WIDTH'(sh_a - {1'b0, m}) : sh_a[WIDTH-1:0];
    b_step = (sh_b >= {1'b0, m}) ? WIDTH'(sh_b - {1'b0, m}) : sh_b[WIDTH-1:0];
    r_ge   = (sh_r >= {1'b0, rc});
    r_step = r_ge ? WIDTH'(sh_r - {1'b0, rc}) : sh_r[WIDTH-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = (modulus == '0) ? S_DONE : S_RED;
      S_RED:     if (cnt == CNT_LAST) state_next = S_DISP;
      S_DISP: begin
        case (kind_q)
          KIND_MUL: state_next = S_MUL_DBL;
          KIND_INV: state_next = S_EU_CHK;
          default:  state_next = S_DONE;
        endcase
      end
      S_MUL_DBL: state_next = S_MUL_ADD;
      S_MUL_ADD: state_next = (cnt == CNT_LAST) ? S_DONE : S_MUL_DBL;
      S_EU_CHK:  state_next = (rc == '0) ? S_DONE : S_EU_DIV;
      S_EU_DIV:  state_next = S_EU_ACC;
      S_EU_ACC:  state_next = (cnt == CNT_LAST) ? S_EU_UPD : S_EU_DIV;
      S_EU_UPD:  state_next = S_EU_CHK;
      S_DONE:    if (out_take) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == S_IDLE);
    res_info.done   = (state == S_DONE);
    res_info.status = st;
    result          = res;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_q <= kind;
        m      <= modulus;
        da     <= operand_a;
        db     <= operand_b;
        a      <= '0;
        b      <= '0;
        cnt    <= '0;
        res    <= '0;
        st     <= (modulus == '0) ? ST_ZEROMOD : ST_OK;
      end
      S_RED: begin
        a   <= a_step;
        b   <= b_step;
        da  <= da << 1;
        db  <= db << 1;
        cnt <= cnt + 1'b1;
      end
      S_DISP: begin
        cnt <= '0;
        acc <= '0;
        db  <= b;
        rp  <= a;
        rc  <= m;
        cp  <= (m == WIDTH'(1)) ? '0 : WIDTH'(1);
        cc  <= '0;
        res <= (kind_q == KIND_SUB) ? sm_s : am_s;
      end
      S_MUL_DBL: acc <= am_s;
      S_MUL_ADD: begin
        if (db[WIDTH-1]) acc <= am_s;
        res <= db[WIDTH-1] ? am_s : acc;
        db  <= db << 1;
        cnt <= cnt + 1'b1;
      end
      S_EU_CHK: begin
        dv  <= rp;
        rem <= '0;
        acc <= '0;
        cnt <= '0;
        if (rp == WIDTH'(1)) begin
          res <= cp;
          st  <= ST_OK;
        end else begin
          res <= '0;
          st  <= ST_NOINV;
        end
      end
      // quotient bit and doubling of q*cc run side by side
      S_EU_DIV: begin
        rem  <= r_step;
        qbit <= r_ge;
        dv   <= dv << 1;
        acc  <= am_s;
      end
      S_EU_ACC: begin
        if (qbit) acc <= am_s;
        cnt <= cnt + 1'b1;
      end
      S_EU_UPD: begin
        rp <= rc;
        rc <= rem;
        cp <= cc;
        cc <= sm_s;
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_res_below_mod, clk, rst,
    res_info.done && st == ST_OK |-> res < m, "result not reduced below modulus")
  `ASSERT_CLK(a_err_zero, clk, rst,
    res_info.done && st != ST_OK |-> res == '0, "error result is not zero")
  `ASSERT_CLK(a_zero_mod_flag, clk, rst,
    res_info.done && m == '0 |-> st == ST_ZEROMOD, "zero modulus not flagged")
  `ASSERT_CLK(a_ready_excl, clk, rst, !(in_ready && res_info.done), "ready while done")

endmodule
`default_nettype wire
